@@ hdl/btpc_pkg.sv @@
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared widths, constants and register codes for the barometer compensation
// core.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int RAW_W     = 20;
  localparam int TEMP_W    = 24;
  localparam int PRESS_W   = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int TFINE_OFFSET = 128000;
  localparam int PRESS_FULL   = 1048576;
  localparam int PRESS_SCALE  = 3125;

  // Pipeline shape: front arithmetic, one divider stage per quotient bit,
  // back arithmetic.
  localparam int FRONT_STAGES = 11;
  localparam int DIV_BITS     = 64;
  localparam int BACK_STAGES  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1    = 3'd0,
    REG_T2_T3 = 3'd1,
    REG_P1    = 3'd2,
    REG_P2_P3 = 3'd3,
    REG_P4_P5 = 3'd4,
    REG_P6_P7 = 3'd5,
    REG_P8_P9 = 3'd6
  } btpc_reg_t;

endpackage

@@ hdl/btpc_if.sv @@
// ----------------------------------------------------------------------------
// btpc_if
// Valid/ready channels of the barometer compensation core: raw samples in,
// compensated results out.
// ----------------------------------------------------------------------------
interface btpc_in_if;
  import btpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temp;
  logic [RAW_W-1:0] raw_press;
  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface btpc_out_if;
  import btpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TEMP_W-1:0]  temp_centi;
  logic [PRESS_W-1:0] press_pascal;
  logic               divide_fault;
  modport source (output valid, temp_centi, press_pascal, divide_fault, input ready);
  modport sink   (input valid, temp_centi, press_pascal, divide_fault, output ready);
endinterface

@@ hdl/baro_temp_press_compensation_core.sv @@
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_core
// Integer trim compensation of raw barometer temperature and pressure.
// ----------------------------------------------------------------------------
// Usage:
//   sample : raw 20-bit temperature and pressure, one pair per transfer.
//   result : temperature in 0.01 degC (signed), pressure in Pa and a flag
//            that is set when the pressure divisor was zero (pressure 0).
//   cfg_*  : trim registers, written while no sample is in flight.
// Throughput: one sample per cycle while the output is not stalled. The path from the
//   sample transfer to the result transfer runs through 11 front stages (ten
//   arithmetic plus the divider input), 64 stages of the restoring divider
//   (one quotient bit each) and 6 stages after it, plus the output register.
// Reset clears the trim registers and all valid bits; nothing is lost or
//   repeated over a stall.
// Stall: a result held in the output register while the receiver is not
//   ready freezes the pipeline only once its last stage is occupied; bubbles
//   ahead of it still close up and new samples are still taken meanwhile.
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_core (
  input  logic                      clk,
  input  logic                      rst,
  btpc_in_if.sink                   sample,
  btpc_out_if.source                result,
  input  logic                      cfg_we,
  input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [btpc_pkg::CFG_W-1:0]     cfg_data
);
  import btpc_pkg::*;

  localparam int LAT = FRONT_STAGES + DIV_BITS + BACK_STAGES;

  // trim registers
  logic [15:0] trim_t1, trim_p1;
  logic [31:0] trim_t2_t3, trim_p2_p3, trim_p4_p5, trim_p6_p7, trim_p8_p9;

  logic [LAT-1:0] vld;
  logic           en;
  logic           accept;

  // front stages
  logic [33:0] s1_pa, s1_dsq;
  logic [20:0] s1_pd;
  logic [31:0] s2_a;
  logic [35:0] s2_pb;
  logic [20:0] s2_pd;
  logic [31:0] s3_fine;
  logic [20:0] s3_pd;
  logic [23:0] s4_temp;
  logic [32:0] s4_v1;
  logic [20:0] s4_pd;
  logic [23:0] s5_temp;
  logic [31:0] s5_abs;
  logic [48:0] s5_v1p5, s5_v1p2;
  logic [20:0] s5_pd;
  logic [23:0] s6_temp;
  logic [63:0] s6_sq;
  logic [48:0] s6_v1p5, s6_v1p2;
  logic [20:0] s6_pd;
  logic [23:0] s7_temp;
  logic [63:0] s7_sqp6, s7_sqp3, s7_v2b, s7_v1p2;
  logic [20:0] s7_pd;
  logic [23:0] s8_temp;
  logic [63:0] s8_v2, s8_va;
  logic [20:0] s8_pd;
  logic [23:0] s9_temp;
  logic [63:0] s9_s, s9_t;
  logic [23:0] s10_temp;
  logic [63:0] s10_m, s10_n;

  // divider stages
  logic [30:0] dv_rem  [0:DIV_BITS];
  logic [63:0] dv_dq   [0:DIV_BITS];
  logic [30:0] dv_ad   [0:DIV_BITS];
  logic [23:0] dv_temp [0:DIV_BITS];
  logic        dv_neg  [0:DIV_BITS];
  logic        dv_flt  [0:DIV_BITS];
  logic [30:0] dv_rem_next [0:DIV_BITS-1];
  logic [63:0] dv_dq_next  [0:DIV_BITS-1];

  // back stages
  logic [23:0] b1_temp, b2_temp, b3_temp, b4_temp, b5_temp, b6_temp;
  logic        b1_flt, b2_flt, b3_flt, b4_flt, b5_flt, b6_flt;
  logic [63:0] b1_p, b2_p, b3_p, b4_p, b5_p;
  logic [50:0] b2_ph;
  logic [63:0] b2_w2p;
  logic [63:0] b3_ll, b3_w2;
  logic [50:0] b3_hl;
  logic [63:0] b4_ph2, b4_w2, b5_w1p, b5_w2;
  logic [63:0] b6_sum;

  logic [17:0] x_diff;
  logic [16:0] d_diff;
  logic [31:0] fine5;
  logic [32:0] v1_neg;
  logic [30:0] div_s;
  logic [31:0] r32;

  assign en           = !(vld[LAT-1] && result.valid && !result.ready);
  assign sample.ready = en;
  assign accept       = sample.valid && en;

  // trim register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_t1    <= '0;
      trim_t2_t3 <= '0;
      trim_p1    <= '0;
      trim_p2_p3 <= '0;
      trim_p4_p5 <= '0;
      trim_p6_p7 <= '0;
      trim_p8_p9 <= '0;
    end else if (cfg_we) begin
      unique case (btpc_reg_t'(cfg_idx))
        REG_T1:    trim_t1    <= cfg_data[15:0];
        REG_T2_T3: trim_t2_t3 <= cfg_data;
        REG_P1:    trim_p1    <= cfg_data[15:0];
        REG_P2_P3: trim_p2_p3 <= cfg_data;
        REG_P4_P5: trim_p4_p5 <= cfg_data;
        REG_P6_P7: trim_p6_p7 <= cfg_data;
        REG_P8_P9: trim_p8_p9 <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // front-end helper terms
  always_comb begin
    x_diff = 18'({1'b0, sample.raw_temp[19:3]}) - 18'({trim_t1, 1'b0});
    d_diff = 17'({1'b0, sample.raw_temp[19:4]}) - 17'(trim_t1);
    fine5  = s3_fine + {s3_fine[29:0], 2'b00} + 32'd128;
    v1_neg = 33'd0 - s4_v1;
    div_s  = s10_m[63:33];
  end

  // front pipeline: temperature, then the pressure coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pa  <= 34'($signed(x_diff) * $signed(trim_t2_t3[15:0]));
      s1_dsq <= 34'($signed(d_diff) * $signed(d_diff));
      s1_pd  <= 21'(PRESS_FULL) - 21'(sample.raw_press);

      s2_a  <= 32'($signed(s1_pa[31:0]) >>> 11);
      s2_pb <= 36'($signed(s1_dsq[31:12]) * $signed(trim_t2_t3[31:16]));
      s2_pd <= s1_pd;

      s3_fine <= s2_a + {{14{s2_pb[31]}}, s2_pb[31:14]};
      s3_pd   <= s2_pd;

      s4_temp <= fine5[31:8];
      s4_v1   <= {s3_fine[31], s3_fine} - 33'(TFINE_OFFSET);
      s4_pd   <= s3_pd;

      s5_temp <= s4_temp;
      s5_abs  <= s4_v1[32] ? v1_neg[31:0] : s4_v1[31:0];
      s5_v1p5 <= 49'($signed(s4_v1) * $signed(trim_p4_p5[31:16]));
      s5_v1p2 <= 49'($signed(s4_v1) * $signed(trim_p2_p3[15:0]));
      s5_pd   <= s4_pd;

      s6_temp <= s5_temp;
      s6_sq   <= 64'(s5_abs * s5_abs);
      s6_v1p5 <= s5_v1p5;
      s6_v1p2 <= s5_v1p2;
      s6_pd   <= s5_pd;

      s7_temp <= s6_temp;
      s7_sqp6 <= 64'($signed({1'b0, s6_sq}) * $signed(trim_p6_p7[15:0]));
      s7_sqp3 <= 64'($signed({1'b0, s6_sq}) * $signed(trim_p2_p3[31:16]));
      s7_v2b  <= ({{15{s6_v1p5[48]}}, s6_v1p5} << 17)
               + ({{48{trim_p4_p5[15]}}, trim_p4_p5[15:0]} << 35);
      s7_v1p2 <= {{15{s6_v1p2[48]}}, s6_v1p2} << 12;
      s7_pd   <= s6_pd;

      s8_temp <= s7_temp;
      s8_v2   <= s7_sqp6 + s7_v2b;
      s8_va   <= 64'($signed(s7_sqp3) >>> 8) + s7_v1p2;
      s8_pd   <= s7_pd;

      s9_temp <= s8_temp;
      s9_s    <= 64'h0000_8000_0000_0000 + s8_va;
      s9_t    <= 64'({s8_pd, 31'b0}) - s8_v2;

      s10_temp <= s9_temp;
      s10_m    <= 64'(s9_s * trim_p1);
      s10_n    <= 64'(s9_t * 12'(PRESS_SCALE));
    end
  end

  // restoring divide step: one quotient bit per stage
  always_comb begin
    logic [31:0] trial;
    logic [31:0] diff;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {dv_rem[k], dv_dq[k][63]};
      diff  = trial - {1'b0, dv_ad[k]};
      if (trial >= {1'b0, dv_ad[k]}) begin
        dv_rem_next[k] = diff[30:0];
        dv_dq_next[k]  = {dv_dq[k][62:0], 1'b1};
      end else begin
        dv_rem_next[k] = trial[30:0];
        dv_dq_next[k]  = {dv_dq[k][62:0], 1'b0};
      end
    end
  end

  // divider input (magnitudes and signs), then advance the divide stages
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= '0;
      dv_dq[0]   <= s10_n[63] ? (64'd0 - s10_n) : s10_n;
      dv_ad[0]   <= div_s[30] ? (31'd0 - div_s) : div_s;
      dv_neg[0]  <= s10_n[63] ^ div_s[30];
      dv_flt[0]  <= (div_s == '0);
      dv_temp[0] <= s10_temp;
      for (int k = 0; k < DIV_BITS; k++) begin
        dv_rem[k+1]  <= dv_rem_next[k];
        dv_dq[k+1]   <= dv_dq_next[k];
        dv_ad[k+1]   <= dv_ad[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_flt[k+1]  <= dv_flt[k];
        dv_temp[k+1] <= dv_temp[k];
      end
    end
  end

  assign r32 = b6_sum[39:8] + ({{16{trim_p6_p7[31]}}, trim_p6_p7[31:16]} << 4);

  // back pipeline: sign restore and the second-order pressure trims
  always_ff @(posedge clk) begin
    if (en) begin
      b1_temp <= dv_temp[DIV_BITS];
      b1_flt  <= dv_flt[DIV_BITS];
      b1_p    <= dv_neg[DIV_BITS] ? (64'd0 - dv_dq[DIV_BITS]) : dv_dq[DIV_BITS];

      b2_temp <= b1_temp;
      b2_flt  <= b1_flt;
      b2_p    <= b1_p;
      b2_ph   <= b1_p[63] ? (51'd0 - b1_p[63:13]) : b1_p[63:13];
      b2_w2p  <= 64'($signed(b1_p) * $signed(trim_p8_p9[15:0]));

      b3_temp <= b2_temp;
      b3_flt  <= b2_flt;
      b3_p    <= b2_p;
      b3_ll   <= 64'(b2_ph[31:0] * b2_ph[31:0]);
      b3_hl   <= 51'(b2_ph[50:32] * b2_ph[31:0]);
      b3_w2   <= 64'($signed(b2_w2p) >>> 19);

      b4_temp <= b3_temp;
      b4_flt  <= b3_flt;
      b4_p    <= b3_p;
      b4_ph2  <= b3_ll + {b3_hl[30:0], 33'b0};
      b4_w2   <= b3_w2;

      b5_temp <= b4_temp;
      b5_flt  <= b4_flt;
      b5_p    <= b4_p;
      b5_w1p  <= 64'($signed(b4_ph2) * $signed(trim_p8_p9[31:16]));
      b5_w2   <= b4_w2;

      b6_temp <= b5_temp;
      b6_flt  <= b5_flt;
      b6_sum  <= b5_p + 64'($signed(b5_w1p) >>> 25) + b5_w2;
    end
  end

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (result.ready || !result.valid) begin
      result.valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !result.valid) begin
      result.temp_centi   <= b6_temp;
      result.press_pascal <= b6_flt ? '0 : r32[31:8];
      result.divide_fault <= b6_flt;
    end
  end

endmodule

@@ bench/btpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_checker
// Watches the sample and result channels of the compensation core, predicts
// each result from the trims it sees written and compares in order.
// ----------------------------------------------------------------------------
module btpc_checker (
  input  logic                           clk,
  input  logic                           rst,
  btpc_in_if                             sample,
  btpc_out_if                            result,
  input  logic                           cfg_we,
  input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [btpc_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             n_results,
  output int                             n_faults
);
  import btpc_pkg::*;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_centi;
    logic [PRESS_W-1:0] press_pascal;
    logic               divide_fault;
  } comp_result_t;

  logic [31:0]  trims [7];
  comp_result_t expected_q [$];

  // Sign-extend one 16-bit trim half to 64 bits
  function automatic logic signed [63:0] trim16(logic [15:0] v);
    return 64'(signed'(v));
  endfunction

  function automatic comp_result_t compensate(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
    comp_result_t r;
    logic signed [31:0] t1, t2, t3, a, d, b, fine, tc;
    logic signed [63:0] v1, v2, p, ph, w1, w2, q;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] an, ad, uq;
    logic [31:0] plow;
    t1 = {16'd0, trims[REG_T1][15:0]};
    t2 = 32'(signed'(trims[REG_T2_T3][15:0]));
    t3 = 32'(signed'(trims[REG_T2_T3][31:16]));
    p1 = {48'd0, trims[REG_P1][15:0]};
    p2 = trim16(trims[REG_P2_P3][15:0]); p3 = trim16(trims[REG_P2_P3][31:16]);
    p4 = trim16(trims[REG_P4_P5][15:0]); p5 = trim16(trims[REG_P4_P5][31:16]);
    p6 = trim16(trims[REG_P6_P7][15:0]); p7 = trim16(trims[REG_P6_P7][31:16]);
    p8 = trim16(trims[REG_P8_P9][15:0]); p9 = trim16(trims[REG_P8_P9][31:16]);
    // temperature path, wraps at 32 bits
    a = (($signed({15'd0, rt[19:3]}) - (t1 <<< 1)) * t2) >>> 11;
    d = $signed({16'd0, rt[19:4]}) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    tc = (fine * 5 + 128) >>> 8;
    r.temp_centi = tc[TEMP_W-1:0];
    // pressure path, wraps at 64 bits
    v1 = 64'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press_pascal = '0;
      r.divide_fault = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'd0, rp});
      p = ((p <<< 31) - v2) * 64'sd3125;
      // truncating divide on magnitudes; most negative / -1 wraps
      an = p[63] ? -p : p;
      ad = v1[63] ? -v1 : v1;
      uq = an / ad;
      q = (p[63] != v1[63]) ? -$signed(uq) : $signed(uq);
      ph = q >>> 13;
      w1 = (p9 * ph * ph) >>> 25;
      w2 = (p8 * q) >>> 19;
      q = ((q + w1 + w2) >>> 8) + (p7 <<< 4);
      plow = q[31:0];
      r.press_pascal = 24'(plow / 256);
      r.divide_fault = 1'b0;
    end
    return r;
  endfunction

  // Track trim writes and compare transfers
  always @(posedge clk) begin
    comp_result_t got, want;
    if (rst) begin
      for (int i = 0; i < 7; i++) trims[i] <= '0;
      expected_q.delete();
      fail_count <= 0;
      n_results <= 0;
      n_faults <= 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.temp_centi, result.press_pascal, result.divide_fault};
        n_results <= n_results + 1;
        if (got.divide_fault) n_faults <= n_faults + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch temp exp %h got %h, press exp %h got %h, fault exp %b got %b",
                     $time, want.temp_centi, got.temp_centi, want.press_pascal,
                     got.press_pascal, want.divide_fault, got.divide_fault);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (sample.valid && sample.ready)
        expected_q.push_back(compensate(sample.raw_temp, sample.raw_press));
      if (cfg_we && cfg_idx < 7)
        trims[cfg_idx] <= (cfg_idx == REG_T1 || cfg_idx == REG_P1) ?
                          {16'd0, cfg_data[15:0]} : cfg_data;
    end
  end

  assign pending = expected_q.size();

endmodule

@@ bench/tb_baro_temp_press_compensation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_press_compensation_core
// Drives samples through the compensation core under several trim sets and
// idling patterns; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_baro_temp_press_compensation_core;
  import btpc_pkg::*;

  localparam int LATENCY = 82;
  localparam int LIMIT   = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, pending, n_results, n_faults;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int cycles = 0;

  btpc_in_if  sample_ch ();
  btpc_out_if result_ch ();

  baro_temp_press_compensation_core u_top (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  btpc_checker u_chk (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .n_results(n_results), .n_faults(n_faults)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) result_ch.ready <= 0;
    else if (hold_off) result_ch.ready <= 0;
    else result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("baro_temp_press_compensation_core test failed");
      $finish;
    end
  end

  // Drive one trim write; the caller drops the write enable afterwards
  task automatic write_trim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_trims(logic [CFG_W-1:0] v [7]);
    for (int i = 0; i < 7; i++) write_trim(CFG_IDX_W'(i), v[i]);
    cfg_we <= 0;
  endtask

  // Offer one sample, with optional idle gaps, and wait for its transfer
  task automatic send_sample(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 0;
      @(posedge clk);
    end
    sample_ch.valid <= 1;
    sample_ch.raw_temp <= rt;
    sample_ch.raw_press <= rp;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Drop the sample offer and wait until every result has come back
  task automatic drain();
    sample_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(3))
      0: return RAW_W'($urandom_range(20'hFFFFF));
      1: return RAW_W'($urandom_range(600000, 350000));
      2: return $urandom_range(1) ? 20'hFFFFF : 20'h0;
      default: return RAW_W'(1 << $urandom_range(19));
    endcase
  endfunction

  logic [CFG_W-1:0] typical [7] = '{32'd27504, {16'hFE18, 16'd26435}, 32'd36477,
                                    {16'd3024, 16'hD6D0}, {16'hFF79, 16'd2855},
                                    {16'h3AB0, 16'hFFF9}, {16'd6000, 16'hE80C}};
  logic [CFG_W-1:0] zeros [7] = '{default: 32'h0};
  logic [CFG_W-1:0] ones  [7] = '{default: 32'hFFFF_FFFF};
  logic [CFG_W-1:0] highs [7] = '{32'hFFFF, 32'h7FFF_7FFF, 32'hFFFF, 32'h7FFF_7FFF,
                                  32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF};
  logic [CFG_W-1:0] lows  [7] = '{32'h0, 32'h8000_8000, 32'h1, 32'h8000_8000,
                                  32'h8000_8000, 32'h8000_8000, 32'h8000_8000};
  logic [CFG_W-1:0] rnd [7];

  initial begin
    sample_ch.valid = 0;
    sample_ch.raw_temp = '0;
    sample_ch.raw_press = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default zero trims give divide faults, then typical trims
    load_trims(zeros);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    load_trims(typical);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'd256000, 20'd500000);
    drain();
    // Extreme trim sets, including an unknown index write that must be ignored
    load_trims(highs);
    send_sample(20'hFFFFF, 20'h0); send_sample(20'h0, 20'hFFFFF);
    send_sample(20'h80000, 20'h7FFFF);
    drain();
    load_trims(lows);
    send_sample(20'hFFFFF, 20'h0); send_sample(20'h0, 20'hFFFFF);
    send_sample(20'h80000, 20'h7FFFF);
    drain();
    for (int i = 0; i < 7; i++) write_trim(CFG_IDX_W'(i), ones[i]);
    write_trim(3'd7, 32'h1234_5678);
    cfg_we <= 0;
    send_sample(20'hFFFFF, 20'hFFFFF); send_sample(20'h0, 20'h0);
    drain();

    // Random phases: trim set and idling pattern change per phase
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) load_trims(typical);
      else begin
        for (int i = 0; i < 7; i++) rnd[i] = $urandom;
        load_trims(rnd);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (ph == 4) begin
        // Long receiver hold-off while samples keep coming
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          for (int n = 0; n < 200; n++) send_sample(rand_raw(), rand_raw());
        join
      end else begin
        for (int n = 0; n < 100; n++) send_sample(rand_raw(), rand_raw());
      end
      drain();
    end

    $display("Covered zero, extreme, typical and random trim sets over idle and stall mixes;");
    $display("%0d results checked, %0d with divide fault.", n_results, n_faults);
    if (fail_count == 0) begin
      $display("baro_temp_press_compensation_core test passed");
    end else begin
      $display("baro_temp_press_compensation_core test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/btpc_pkg.sv
hdl/btpc_if.sv
hdl/baro_temp_press_compensation_core.sv
bench/btpc_checker.sv
bench/tb_baro_temp_press_compensation_core.sv
